// ===== hdl/hrl_pkg.sv =====
// shared types, constants and tables for the heading rate limiter
`default_nettype none
package hrl_pkg;

    localparam int CORDIC_STAGES_DEF = 14;
    localparam int CFG_IDX_W = 8;
    localparam int CFG_DATA_W = 32;
    localparam int MUL_W = 32;
    localparam int DVD_W = 35;
    localparam int DVS_W = 20;
    localparam int ANG_W = 19;

    localparam logic [CFG_IDX_W-1:0] CFG_MAX_TURN_RATE = 8'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MIN_DIR_LEN = 8'd1;

    localparam logic [14:0] MTR_RESET = 15'd25736;
    localparam logic [16:0] MDL_RESET = 17'd6554;
    localparam logic [DVS_W-1:0] US_PER_S = 20'd1000000;

    localparam logic signed [ANG_W-1:0] ANG_PI = 19'sd25736;
    localparam logic signed [ANG_W-1:0] ANG_2PI = 19'sd51472;

    typedef struct packed {
        logic signed [31:0] dir_x;
        logic signed [31:0] dir_y;
        logic [19:0] elapsed_us;
    } t_in_item;

    typedef struct packed {
        logic signed [15:0] heading;
        logic signed [15:0] heading_rate;
    } t_out_item;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_MUL_X,
        ST_MUL_Y,
        ST_MUL_T,
        ST_TEST,
        ST_CORDIC,
        ST_MUL_C,
        ST_DIV_C,
        ST_MUL_Q,
        ST_DIV_Q,
        ST_DONE
    } t_state;

    function automatic logic [12:0] atan_entry(input logic [3:0] idx);
        logic [12:0] v;
        case (idx)
            4'd0: v = 13'd6434;
            4'd1: v = 13'd3798;
            4'd2: v = 13'd2007;
            4'd3: v = 13'd1019;
            4'd4: v = 13'd511;
            4'd5: v = 13'd256;
            4'd6: v = 13'd128;
            4'd7: v = 13'd64;
            4'd8: v = 13'd32;
            4'd9: v = 13'd16;
            4'd10: v = 13'd8;
            4'd11: v = 13'd4;
            4'd12: v = 13'd2;
            4'd13: v = 13'd1;
            default: v = 13'd0;
        endcase
        return v;
    endfunction

endpackage
`default_nettype wire

// ===== hdl/hrl_smul.sv =====
// bit-serial shift-add multiplier, one multiplier bit per cycle
`default_nettype none
module hrl_smul (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_start,
    input  wire logic [hrl_pkg::MUL_W-1:0]     i_a,
    input  wire logic [hrl_pkg::MUL_W-1:0]     i_b,
    output logic                               o_done,
    output logic [2*hrl_pkg::MUL_W-1:0]        o_prod
);
    localparam int W = hrl_pkg::MUL_W;
    localparam int CW = $clog2(W);

    logic [2*W-1:0] r_acc;
    logic [W-1:0]   r_a;
    logic [W-1:0]   r_b;
    logic [CW-1:0]  r_cnt;
    logic           r_busy;
    logic           r_done;
    logic [W:0]     n_sum;

    always_comb begin
        n_sum = {1'b0, r_acc[2*W-1:W]} + (r_b[0] ? {1'b0, r_a} : {(W+1){1'b0}});
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == CW'(W-1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_acc <= '0;
            r_a   <= i_a;
            r_b   <= i_b;
        end else if (r_busy) begin
            r_acc <= {n_sum, r_acc[W-1:1]};
            r_b   <= {1'b0, r_b[W-1:1]};
        end
    end

    assign o_done = r_done;
    assign o_prod = r_acc;
endmodule
`default_nettype wire

// ===== hdl/hrl_sdiv.sv =====
// bit-serial restoring divider, one quotient bit per cycle
`default_nettype none
module hrl_sdiv (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_start,
    input  wire logic [hrl_pkg::DVD_W-1:0]     i_dvd,
    input  wire logic [hrl_pkg::DVS_W-1:0]     i_dvs,
    output logic                               o_done,
    output logic [hrl_pkg::DVD_W-1:0]          o_quo
);
    localparam int QW = hrl_pkg::DVD_W;
    localparam int SW = hrl_pkg::DVS_W;
    localparam int CW = $clog2(QW);

    logic [QW-1:0] r_q;
    logic [SW-1:0] r_rem;
    logic [SW-1:0] r_dvs;
    logic [CW-1:0] r_cnt;
    logic          r_busy;
    logic          r_done;
    logic [SW:0]   n_trial;
    logic [SW:0]   n_diff;
    logic          n_bit;

    always_comb begin
        n_trial = {r_rem, r_q[QW-1]};
        n_diff  = n_trial - {1'b0, r_dvs};
        n_bit   = (n_trial >= {1'b0, r_dvs});
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == CW'(QW-1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_q   <= i_dvd;
            r_rem <= '0;
            r_dvs <= i_dvs;
        end else if (r_busy) begin
            r_rem <= n_bit ? n_diff[SW-1:0] : n_trial[SW-1:0];
            r_q   <= {r_q[QW-2:0], n_bit};
        end
    end

    assign o_done = r_done;
    assign o_quo  = r_q;
endmodule
`default_nettype wire

// ===== hdl/hrl_cordic.sv =====
// iterative vectoring cordic, one rotation per cycle, gives atan2 in q3.13
`default_nettype none
module hrl_cordic #(
    parameter int STAGES = hrl_pkg::CORDIC_STAGES_DEF
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_start,
    input  wire logic signed [31:0] i_x,
    input  wire logic signed [31:0] i_y,
    output logic                    o_done,
    output logic signed [15:0]      o_angle
);
    localparam int XW = 52;
    localparam int CW = $clog2(STAGES);
    localparam int AW = hrl_pkg::ANG_W;

    logic signed [XW-1:0] r_x;
    logic signed [XW-1:0] r_y;
    logic signed [AW-1:0] r_z;
    logic [CW-1:0]        r_cnt;
    logic                 r_busy;
    logic                 r_done;

    logic signed [XW-1:0] n_x0;
    logic signed [XW-1:0] n_y0;
    logic signed [AW-1:0] n_z0;
    logic signed [XW-1:0] n_xs;
    logic signed [XW-1:0] n_ys;
    logic signed [AW-1:0] n_tab;
    logic signed [AW-1:0] n_wrap;

    always_comb begin
        if (i_x < 0) begin
            n_x0 = -(XW'(i_x)) <<< 16;
            n_y0 = -(XW'(i_y)) <<< 16;
            n_z0 = (i_y >= 0) ? hrl_pkg::ANG_PI : -hrl_pkg::ANG_PI;
        end else begin
            n_x0 = XW'(i_x) <<< 16;
            n_y0 = XW'(i_y) <<< 16;
            n_z0 = '0;
        end
        n_xs  = r_x >>> r_cnt;
        n_ys  = r_y >>> r_cnt;
        n_tab = AW'(hrl_pkg::atan_entry(4'(r_cnt)));
        if (r_z > hrl_pkg::ANG_PI) begin
            n_wrap = r_z - hrl_pkg::ANG_2PI;
        end else if (r_z < -hrl_pkg::ANG_PI) begin
            n_wrap = r_z + hrl_pkg::ANG_2PI;
        end else begin
            n_wrap = r_z;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == CW'(STAGES-1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_x <= n_x0;
            r_y <= n_y0;
            r_z <= n_z0;
        end else if (r_busy) begin
            if (r_y >= 0) begin
                r_x <= r_x + n_ys;
                r_y <= r_y - n_xs;
                r_z <= r_z + n_tab;
            end else begin
                r_x <= r_x - n_ys;
                r_y <= r_y + n_xs;
                r_z <= r_z - n_tab;
            end
        end
    end

    assign o_done  = r_done;
    assign o_angle = n_wrap[15:0];
endmodule
`default_nettype wire

// ===== hdl/heading_rate_limiter_core.sv =====
// top level of the heading rate limiter: sequencer, limit logic and filter state
// from input accept to output valid: three multiplier passes, the length test, the cordic pass,
// then multiplier, divider, multiplier, divider and the output load; the cordic pass is skipped
// when the vector is short and the held heading is used as the target
// one item at a time; input waits for the output load, which waits while the output is stalled
// synchronous active-low reset clears state, filter history and registers to defaults
`default_nettype none
module heading_rate_limiter_core #(
    parameter int CORDIC_STAGES = hrl_pkg::CORDIC_STAGES_DEF
) (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire logic                              i_in_valid,
    output logic                                   o_in_stall,
    input  wire hrl_pkg::t_in_item                 i_in,
    output logic                                   o_out_valid,
    input  wire logic                              i_out_stall,
    output hrl_pkg::t_out_item                     o_out,
    input  wire logic                              i_cfg_valid,
    output logic                                   o_cfg_ready,
    input  wire logic [hrl_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  wire logic [hrl_pkg::CFG_DATA_W-1:0]    i_cfg_data
);
    localparam int AW = hrl_pkg::ANG_W;

    hrl_pkg::t_state r_state, n_state;
    logic r_run, n_run;
    logic r_out_valid;
    hrl_pkg::t_out_item r_out;

    logic [14:0] r_mtr;
    logic [16:0] r_mdl;
    logic signed [15:0] r_prev_h;
    logic signed [15:0] r_prev_r;

    logic signed [31:0] r_dx;
    logic signed [31:0] r_dy;
    logic [31:0] r_ax;
    logic [31:0] r_ay;
    logic [19:0] r_el;
    logic [63:0] r_len2;
    logic [33:0] r_thr2;
    logic signed [15:0] r_target;
    logic [14:0] r_change;

    logic mul_start, mul_done;
    logic [31:0] mul_a, mul_b;
    logic [63:0] mul_prod;
    logic div_start, div_done;
    logic [hrl_pkg::DVD_W-1:0] div_dvd, div_quo;
    logic [hrl_pkg::DVS_W-1:0] div_dvs;
    logic cor_start, cor_done;
    logic signed [15:0] cor_angle;

    logic accept, load_out;

    logic signed [AW-1:0] prev_s, ch_s, rmax_s, diff, diff_mag;
    logic signed [AW-1:0] plus_w, minus_w, yaw, rate, step, qrate, yaw_f, rate_f;
    logic signed [AW-1:0] qmag;

    assign accept = (r_state == hrl_pkg::ST_IDLE) && i_in_valid;
    assign o_in_stall = (r_state != hrl_pkg::ST_IDLE);
    assign o_cfg_ready = 1'b1;
    assign o_out_valid = r_out_valid;
    assign o_out = r_out;

    hrl_smul u_mul (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(mul_start),
        .i_a(mul_a), .i_b(mul_b), .o_done(mul_done), .o_prod(mul_prod)
    );

    hrl_sdiv u_div (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(div_start),
        .i_dvd(div_dvd), .i_dvs(div_dvs), .o_done(div_done), .o_quo(div_quo)
    );

    hrl_cordic #(.STAGES(CORDIC_STAGES)) u_cordic (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(cor_start),
        .i_x(r_dx), .i_y(r_dy), .o_done(cor_done), .o_angle(cor_angle)
    );

    // limit and filter
    always_comb begin
        prev_s   = AW'(r_prev_h);
        ch_s     = AW'({1'b0, r_change});
        rmax_s   = AW'({1'b0, r_mtr});
        diff     = AW'(r_target) - prev_s;
        diff_mag = (diff < 0) ? -diff : diff;
        plus_w   = prev_s + ch_s;
        if (plus_w > hrl_pkg::ANG_PI) begin
            plus_w = plus_w - hrl_pkg::ANG_2PI;
        end
        minus_w = prev_s - ch_s;
        if (minus_w < -hrl_pkg::ANG_PI) begin
            minus_w = minus_w + hrl_pkg::ANG_2PI;
        end
        qmag = AW'({1'b0, div_quo[15:0]});
        if (diff < 0) begin
            qrate = (div_quo > 35'd32768) ? -19'sd32768 : -qmag;
        end else begin
            qrate = (div_quo > 35'd32767) ? 19'sd32767 : qmag;
        end
        if (diff > hrl_pkg::ANG_PI) begin
            yaw  = (diff - hrl_pkg::ANG_2PI < -ch_s) ? minus_w : AW'(r_target);
            rate = -rmax_s;
        end else if (diff < -hrl_pkg::ANG_PI) begin
            yaw  = (diff + hrl_pkg::ANG_2PI > ch_s) ? plus_w : AW'(r_target);
            rate = rmax_s;
        end else if (diff < -ch_s) begin
            yaw  = minus_w;
            rate = -rmax_s;
        end else if (diff > ch_s) begin
            yaw  = plus_w;
            rate = rmax_s;
        end else begin
            yaw  = AW'(r_target);
            rate = qrate;
        end
        step = yaw - prev_s;
        if (step < 0) begin
            step = -step;
        end
        yaw_f  = (step <= ch_s) ? ((prev_s + yaw) >>> 1) : yaw;
        rate_f = (AW'(r_prev_r) + rate) >>> 1;
    end

    // unit operands
    always_comb begin
        mul_a = '0;
        mul_b = '0;
        case (r_state)
            hrl_pkg::ST_MUL_X: begin
                mul_a = r_ax;
                mul_b = r_ax;
            end
            hrl_pkg::ST_MUL_Y: begin
                mul_a = r_ay;
                mul_b = r_ay;
            end
            hrl_pkg::ST_MUL_T: begin
                mul_a = {15'd0, r_mdl};
                mul_b = {15'd0, r_mdl};
            end
            hrl_pkg::ST_MUL_C: begin
                mul_a = {17'd0, r_mtr};
                mul_b = {12'd0, r_el};
            end
            hrl_pkg::ST_MUL_Q: begin
                mul_a = 32'(unsigned'(diff_mag));
                mul_b = {12'd0, hrl_pkg::US_PER_S};
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
        div_dvd = mul_prod[hrl_pkg::DVD_W-1:0];
        div_dvs = (r_state == hrl_pkg::ST_DIV_Q) ? r_el : hrl_pkg::US_PER_S;
    end

    // sequencer
    always_comb begin
        n_state   = r_state;
        n_run     = r_run;
        mul_start = 1'b0;
        div_start = 1'b0;
        cor_start = 1'b0;
        load_out  = 1'b0;
        case (r_state)
            hrl_pkg::ST_IDLE: begin
                if (i_in_valid) begin
                    n_state = hrl_pkg::ST_MUL_X;
                end
            end
            hrl_pkg::ST_MUL_X, hrl_pkg::ST_MUL_Y, hrl_pkg::ST_MUL_T,
            hrl_pkg::ST_MUL_C, hrl_pkg::ST_MUL_Q: begin
                if (!r_run) begin
                    mul_start = 1'b1;
                    n_run = 1'b1;
                end else if (mul_done) begin
                    n_run = 1'b0;
                    case (r_state)
                        hrl_pkg::ST_MUL_X: n_state = hrl_pkg::ST_MUL_Y;
                        hrl_pkg::ST_MUL_Y: n_state = hrl_pkg::ST_MUL_T;
                        hrl_pkg::ST_MUL_T: n_state = hrl_pkg::ST_TEST;
                        hrl_pkg::ST_MUL_C: n_state = hrl_pkg::ST_DIV_C;
                        default:           n_state = hrl_pkg::ST_DIV_Q;
                    endcase
                end
            end
            hrl_pkg::ST_TEST: begin
                n_state = (r_len2 > {30'd0, r_thr2}) ? hrl_pkg::ST_CORDIC
                                                     : hrl_pkg::ST_MUL_C;
            end
            hrl_pkg::ST_CORDIC: begin
                if (!r_run) begin
                    cor_start = 1'b1;
                    n_run = 1'b1;
                end else if (cor_done) begin
                    n_run = 1'b0;
                    n_state = hrl_pkg::ST_MUL_C;
                end
            end
            hrl_pkg::ST_DIV_C, hrl_pkg::ST_DIV_Q: begin
                if (!r_run) begin
                    div_start = 1'b1;
                    n_run = 1'b1;
                end else if (div_done) begin
                    n_run = 1'b0;
                    n_state = (r_state == hrl_pkg::ST_DIV_C) ? hrl_pkg::ST_MUL_Q
                                                             : hrl_pkg::ST_DONE;
                end
            end
            hrl_pkg::ST_DONE: begin
                if (!r_out_valid || !i_out_stall) begin
                    load_out = 1'b1;
                    n_state = hrl_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = hrl_pkg::ST_IDLE;
                n_run = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= hrl_pkg::ST_IDLE;
            r_run       <= 1'b0;
            r_out_valid <= 1'b0;
            r_mtr       <= hrl_pkg::MTR_RESET;
            r_mdl       <= hrl_pkg::MDL_RESET;
            r_prev_h    <= '0;
            r_prev_r    <= '0;
        end else begin
            r_state <= n_state;
            r_run   <= n_run;
            if (load_out) begin
                r_out_valid <= 1'b1;
                r_prev_h    <= yaw_f[15:0];
                r_prev_r    <= rate_f[15:0];
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
            if (i_cfg_valid) begin
                if (i_cfg_index == hrl_pkg::CFG_MAX_TURN_RATE) begin
                    r_mtr <= i_cfg_data[14:0];
                end else if (i_cfg_index == hrl_pkg::CFG_MIN_DIR_LEN) begin
                    r_mdl <= i_cfg_data[16:0];
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_dx <= i_in.dir_x;
            r_dy <= i_in.dir_y;
            r_ax <= (i_in.dir_x < 0) ? 32'(-i_in.dir_x) : 32'(i_in.dir_x);
            r_ay <= (i_in.dir_y < 0) ? 32'(-i_in.dir_y) : 32'(i_in.dir_y);
            r_el <= (i_in.elapsed_us == 20'd0) ? 20'd1 : i_in.elapsed_us;
        end
        if (mul_done && r_state == hrl_pkg::ST_MUL_X) begin
            r_len2 <= mul_prod;
        end
        if (mul_done && r_state == hrl_pkg::ST_MUL_Y) begin
            r_len2 <= r_len2 + mul_prod;
        end
        if (mul_done && r_state == hrl_pkg::ST_MUL_T) begin
            r_thr2 <= mul_prod[33:0];
        end
        if (r_state == hrl_pkg::ST_TEST) begin
            r_target <= r_prev_h;
        end
        if (cor_done && r_state == hrl_pkg::ST_CORDIC) begin
            r_target <= cor_angle;
        end
        if (div_done && r_state == hrl_pkg::ST_DIV_C) begin
            r_change <= div_quo[14:0];
        end
        if (load_out) begin
            r_out.heading      <= yaw_f[15:0];
            r_out.heading_rate <= rate_f[15:0];
        end
    end
endmodule
`default_nettype wire

// ===== hdl/hrl_checker.sv =====
// port-level checks for the heading rate limiter, bound to the top level
`default_nettype none
module hrl_checker (
    input wire logic               i_clk,
    input wire logic               i_rst_n,
    input wire logic               i_in_valid,
    input wire logic               o_in_stall,
    input wire logic               o_out_valid,
    input wire logic               i_out_stall,
    input wire hrl_pkg::t_out_item o_out
);
    // one item in flight at a time
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall) |=> o_in_stall)
        else $error("input not stalled after accept");

    a_heading_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_out.heading >= -16'sd25736 && o_out.heading <= 16'sd25736))
        else $error("heading outside wrap range");

    a_valid_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_stall) |=> o_out_valid)
        else $error("output valid dropped while stalled");

    a_data_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_stall) |=> $stable(o_out))
        else $error("output item changed while stalled");
endmodule

bind heading_rate_limiter_core hrl_checker u_hrl_checker (
    .i_clk(i_clk),
    .i_rst_n(i_rst_n),
    .i_in_valid(i_in_valid),
    .o_in_stall(o_in_stall),
    .o_out_valid(o_out_valid),
    .i_out_stall(i_out_stall),
    .o_out(o_out)
);
`default_nettype wire
